// File: sv/ofs_pkg.sv
// Package: shared types, status codes and constants of the factor splitter.
package ofs_pkg;
    localparam int WORD_BITS_DEF = 32;
    localparam int STAT_W = 3;
    localparam logic [STAT_W-1:0] ST_INVALID = 3'd0;
    localparam logic [STAT_W-1:0] ST_EVEN    = 3'd1;
    localparam logic [STAT_W-1:0] ST_GCD     = 3'd2;
    localparam logic [STAT_W-1:0] ST_ORDER   = 3'd3;
    localparam logic [STAT_W-1:0] ST_FAIL    = 3'd4;

    typedef enum logic [1:0] {
        OP_MULMOD = 2'd0,
        OP_DIVMOD = 2'd1
    } t_op;
endpackage

// File: sv/ofs_arith.sv
// Bit-serial arithmetic unit: modular multiply (double-and-add) and restoring divide.
module ofs_arith
    import ofs_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_op                  i_op,
    input  logic [WORD_BITS-1:0] i_a,
    input  logic [WORD_BITS-1:0] i_b,
    input  logic [WORD_BITS-1:0] i_n,
    output logic                 o_done,
    output logic [WORD_BITS-1:0] o_q,
    output logic [WORD_BITS-1:0] o_r
);
    localparam int CW = $clog2(WORD_BITS + 1);

    logic                 r_busy;
    t_op                  r_op;
    logic [CW-1:0]        r_cnt;
    logic [WORD_BITS-1:0] r_x;
    logic [WORD_BITS-1:0] r_y;
    logic [WORD_BITS-1:0] r_n;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS:0]   rem_sh;
    logic [WORD_BITS:0]   rem_sub;
    logic [WORD_BITS:0]   acc_dbl;
    logic [WORD_BITS:0]   acc_add;
    logic [WORD_BITS-1:0] acc_nx;

    always_comb begin
        rem_sh  = {r_acc, r_x[WORD_BITS-1]};
        rem_sub = rem_sh - {1'b0, r_n};
        acc_dbl = {r_acc, 1'b0};
        if (acc_dbl >= {1'b0, r_n}) begin
            acc_dbl = acc_dbl - {1'b0, r_n};
        end
        acc_add = acc_dbl + {1'b0, r_y};
        if (acc_add >= {1'b0, r_n}) begin
            acc_add = acc_add - {1'b0, r_n};
        end
        acc_nx = r_x[WORD_BITS-1] ? acc_add[WORD_BITS-1:0] : acc_dbl[WORD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start && !r_busy) begin
            r_busy <= 1'b1;
            r_op   <= i_op;
            r_x    <= i_a;
            r_y    <= i_b;
            r_n    <= i_n;
            r_acc  <= '0;
            r_cnt  <= CW'(WORD_BITS);
        end else if (r_busy) begin
            if (r_op == OP_DIVMOD) begin
                if (!rem_sub[WORD_BITS]) begin
                    r_acc <= rem_sub[WORD_BITS-1:0];
                    r_x   <= {r_x[WORD_BITS-2:0], 1'b1};
                end else begin
                    r_acc <= rem_sh[WORD_BITS-1:0];
                    r_x   <= {r_x[WORD_BITS-2:0], 1'b0};
                end
            end else begin
                r_acc <= acc_nx;
                r_x   <= {r_x[WORD_BITS-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end

    assign o_q = r_x;
    assign o_r = r_acc;
endmodule

// File: sv/order_finding_factor_split.sv
// Top level: sequencer for the order-finding factor splitter.
// Duration is data dependent; each multiply or divide runs on one shared bit-serial unit.
// Trial division runs up to sqrt(n)/2 divides, the order search up to n multiplies;
// small or even n are answered without using the unit.
// Throughput: one request at a time; the next is taken once the result has been taken.
// Reset: synchronous active low i_rst_n returns the sequencer to idle, clears valid.
module order_finding_factor_split
    import ofs_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [WORD_BITS-1:0] i_modulus,
    input  logic [WORD_BITS-1:0] i_base,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [STAT_W-1:0]    o_status,
    output logic [WORD_BITS-1:0] o_factor_one,
    output logic [WORD_BITS-1:0] o_factor_two
);
    typedef enum logic [3:0] {
        S_IDLE, S_RED, S_GCD, S_GCDW, S_SPLIT, S_POW, S_POWW, S_CHK,
        S_G1, S_G2, S_DIV, S_OUT, S_TRY, S_TRYW
    } t_state;

    localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);

    t_state               r_st;
    logic [WORD_BITS-1:0] r_n;
    logic [WORD_BITS-1:0] r_a;
    logic [WORD_BITS-1:0] r_p;
    logic [WORD_BITS-1:0] r_r;
    logic [WORD_BITS-1:0] r_gx;
    logic [WORD_BITS-1:0] r_gy;
    logic [WORD_BITS-1:0] r_f1;
    logic [WORD_BITS-1:0] r_x;
    logic [STAT_W-1:0]    r_stat;
    logic                 r_second;
    logic                 r_go;
    t_op                  r_op;
    logic [WORD_BITS-1:0] r_oa;
    logic [WORD_BITS-1:0] r_ob;
    logic [WORD_BITS-1:0] r_on;
    logic                 a_done;
    logic [WORD_BITS-1:0] a_q;
    logic [WORD_BITS-1:0] a_r;

    ofs_arith #(.WORD_BITS(WORD_BITS)) u_arith (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_go),
        .i_op   (r_op),
        .i_a    (r_oa),
        .i_b    (r_ob),
        .i_n    (r_on),
        .o_done (a_done),
        .o_q    (a_q),
        .o_r    (a_r)
    );

    assign o_stall = (r_st != S_IDLE) || o_valid;

    always_ff @(posedge i_clk) begin
        r_go <= 1'b0;
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_n <= i_modulus;
                        if (i_modulus < WORD_BITS'(4)) begin
                            r_stat <= ST_INVALID;
                            r_f1 <= ONE;
                            r_st <= S_OUT;
                            o_factor_two <= ONE;
                        end else if (!i_modulus[0]) begin
                            r_stat <= ST_EVEN;
                            r_f1 <= WORD_BITS'(2);
                            o_factor_two <= i_modulus >> 1;
                            r_st <= S_OUT;
                        end else begin
                            r_stat <= ST_FAIL;
                            r_f1 <= ONE;
                            r_op <= OP_DIVMOD; r_oa <= i_base; r_on <= i_modulus;
                            r_go <= 1'b1; r_st <= S_RED;
                        end
                    end
                end
                S_RED: if (a_done) begin
                    r_a <= a_r; r_gx <= r_n; r_gy <= a_r; r_st <= S_GCD;
                end
                S_GCD: begin
                    if (r_gy == '0) begin
                        if (r_gx != ONE && r_gx != r_n) begin
                            r_stat <= ST_GCD; r_f1 <= r_gx;
                            r_op <= OP_DIVMOD; r_oa <= r_n; r_on <= r_gx;
                            r_go <= 1'b1; r_st <= S_DIV;
                        end else if (r_gx == r_n) begin
                            r_p <= WORD_BITS'(3); r_st <= S_TRY;
                        end else begin
                            r_p <= r_a; r_r <= ONE; r_st <= S_SPLIT;
                        end
                    end else begin
                        r_op <= OP_DIVMOD; r_oa <= r_gx; r_on <= r_gy;
                        r_go <= 1'b1; r_st <= S_GCDW;
                    end
                end
                S_GCDW: if (a_done) begin
                    r_gx <= r_gy; r_gy <= a_r; r_st <= S_GCD;
                end
                S_TRY: begin
                    r_op <= OP_DIVMOD; r_oa <= r_n; r_on <= r_p;
                    r_go <= 1'b1; r_st <= S_TRYW;
                end
                S_TRYW: if (a_done) begin
                    if (a_q < r_p) begin
                        r_st <= S_OUT; o_factor_two <= ONE;
                    end else if (a_r == '0) begin
                        r_stat <= ST_GCD; r_f1 <= r_n;
                        r_st <= S_OUT; o_factor_two <= ONE;
                    end else begin
                        r_p <= r_p + WORD_BITS'(2); r_st <= S_TRY;
                    end
                end
                S_SPLIT: begin
                    if (r_p == ONE) begin
                        if (r_r[0]) begin
                            r_st <= S_OUT; o_factor_two <= ONE;
                        end else begin
                            r_x <= ONE; r_gx <= r_r >> 1; r_st <= S_POW;
                        end
                    end else if (r_r >= r_n) begin
                        r_st <= S_OUT; o_factor_two <= ONE;
                    end else begin
                        r_op <= OP_MULMOD; r_oa <= r_p; r_ob <= r_a; r_on <= r_n;
                        r_go <= 1'b1; r_st <= S_POWW; r_second <= 1'b0;
                    end
                end
                S_POWW: if (a_done) begin
                    r_p <= a_r; r_r <= r_r + ONE; r_st <= S_SPLIT;
                end
                S_POW: begin
                    if (r_gx == '0) begin
                        r_st <= S_CHK;
                    end else begin
                        r_op <= OP_MULMOD; r_oa <= r_x; r_ob <= r_a; r_on <= r_n;
                        r_go <= 1'b1; r_gx <= r_gx - ONE; r_st <= S_G1;
                        r_second <= 1'b1;
                    end
                end
                S_G1: if (a_done) begin
                    if (r_second) begin
                        r_x <= a_r; r_st <= S_POW;
                    end else begin
                        r_gx <= r_gy; r_gy <= a_r; r_st <= S_G2;
                    end
                end
                S_CHK: begin
                    if (r_x == r_n - ONE) begin
                        r_st <= S_OUT; o_factor_two <= ONE;
                    end else begin
                        r_gx <= r_n; r_gy <= r_x + ONE; r_second <= 1'b0; r_st <= S_G2;
                        r_p <= '0;
                    end
                end
                S_G2: begin
                    if (r_gy == '0) begin
                        if (r_gx > ONE && r_gx < r_n) begin
                            r_stat <= ST_ORDER; r_f1 <= r_gx;
                            r_op <= OP_DIVMOD; r_oa <= r_n; r_on <= r_gx;
                            r_go <= 1'b1; r_st <= S_DIV;
                        end else if (r_p == '0) begin
                            r_p <= ONE; r_gx <= r_n; r_gy <= r_x - ONE;
                        end else begin
                            r_st <= S_OUT; o_factor_two <= ONE;
                        end
                    end else begin
                        r_op <= OP_DIVMOD; r_oa <= r_gx; r_on <= r_gy;
                        r_go <= 1'b1; r_second <= 1'b0; r_st <= S_G1;
                    end
                end
                S_DIV: if (a_done) begin
                    o_factor_two <= a_q; r_st <= S_OUT;
                end
                S_OUT: begin
                    o_status <= r_stat; o_factor_one <= r_f1;
                    o_valid <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> o_stall)
        else $error("request accepted while busy");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= ST_FAIL))
        else $error("bad status");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_factor_one)))
        else $error("result dropped under stall");
endmodule

// File: tb/tb_top.sv
// Testbench for the order-finding factor splitter: directed table, then random requests.
`timescale 1ns / 1ps

module tb_top;
    import ofs_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [31:0]       factor_one;
        logic [31:0]       factor_two;
    } t_split;

    typedef struct {
        logic [31:0] modulus;
        logic [31:0] base;
        bit          typed;
        t_split      split;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [31:0]          i_modulus = '0;
    logic [31:0]          i_base = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [STAT_W-1:0]    o_status;
    logic [31:0]          o_factor_one;
    logic [31:0]          o_factor_two;

    t_split pending_splits[$];
    int     errors = 0;
    int     sent = 0;
    int     received = 0;
    int     order_splits = 0;

    order_finding_factor_split u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_modulus    (i_modulus),
        .i_base       (i_base),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_factor_one (o_factor_one),
        .o_factor_two (o_factor_two)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                                longint unsigned n);
        longint unsigned acc;
        acc = 1 % n;
        b = b % n;
        while (e != 0) begin
            if (e[0]) acc = (acc * b) % n;
            b = (b * b) % n;
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic longint unsigned reduce_order(longint unsigned r, longint unsigned q,
                                                     longint unsigned a, longint unsigned n);
        while (r % q == 0 && pow_mod(a, r / q, n) == 1) r = r / q;
        return r;
    endfunction

    function automatic t_split predict_split(logic [31:0] mod_in, logic [31:0] base_in);
        longint unsigned n, a, m, lam, d, pk, g, r, t, q, x, g1, g2;
        t_split s;
        n = mod_in;
        a = base_in;
        s = '{status: ST_FAIL, factor_one: 32'd1, factor_two: 32'd1};
        if (n < 4) begin
            s.status = ST_INVALID;
        end else if (n[0] == 1'b0) begin
            s = '{status: ST_EVEN, factor_one: 32'd2, factor_two: 32'(n / 2)};
        end else begin
            m = n;
            lam = 1;
            for (d = 3; d <= m / d; d += 2) begin
                if (m % d == 0) begin
                    pk = 1;
                    while (m % d == 0) begin
                        m = m / d;
                        pk = pk * d;
                    end
                    pk = pk / d * (d - 1);
                    lam = lam / gcd_of(lam, pk) * pk;
                end
            end
            if (m != n) begin
                if (m > 1) lam = lam / gcd_of(lam, m - 1) * (m - 1);
                g = gcd_of(a, n);
                if (g > 1) begin
                    s = '{status: ST_GCD, factor_one: 32'(g), factor_two: 32'(n / g)};
                end else begin
                    r = lam;
                    t = lam;
                    for (q = 2; q <= t / q; q += (q == 2) ? 1 : 2) begin
                        if (t % q == 0) begin
                            while (t % q == 0) t = t / q;
                            r = reduce_order(r, q, a, n);
                        end
                    end
                    if (t > 1) r = reduce_order(r, t, a, n);
                    if (r[0] == 1'b0) begin
                        x = pow_mod(a, r / 2, n);
                        if (x != n - 1) begin
                            g1 = gcd_of(x + 1, n);
                            g2 = gcd_of(x - 1, n);
                            if (g1 > 1 && g1 < n)
                                s = '{status: ST_ORDER, factor_one: 32'(g1),
                                      factor_two: 32'(n / g1)};
                            else if (g2 > 1 && g2 < n)
                                s = '{status: ST_ORDER, factor_one: 32'(g2),
                                      factor_two: 32'(n / g2)};
                        end
                    end
                end
            end
        end
        return s;
    endfunction

    task automatic send_request(logic [31:0] modulus, logic [31:0] base, bit typed,
                                t_split typed_split);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_modulus <= modulus;
        i_base <= base;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        pending_splits.push_back(typed ? typed_split : predict_split(modulus, base));
        sent++;
        @(negedge i_clk);
    endtask

    // odd modulus kept small so the order search stays short
    task automatic send_random();
        logic [31:0] modulus;
        logic [31:0] base;
        int kind;
        kind = $urandom_range(0, 9);
        base = $urandom();
        if (kind < 3) modulus = $urandom() & 32'hFFFF_FFFE;
        else if (kind == 3) modulus = $urandom_range(0, 3);
        else modulus = $urandom_range(2, 127) * 2 + 1;
        if (kind == 3 && $urandom_range(0, 1) == 0) modulus = $urandom() & 32'hFFFF_FFFE;
        if (kind >= 4 && $urandom_range(0, 4) == 0) base = $urandom_range(0, 300);
        send_request(modulus, base, 1'b0, '0);
    endtask

    always @(negedge i_clk) begin
        if ($urandom_range(0, 49) == 0) i_stall <= 1'b1;
        else if (i_stall && $urandom_range(0, 7) != 0) i_stall <= 1'b1;
        else i_stall <= ($urandom_range(0, 5) == 0);
    end

    always @(posedge i_clk) begin
        t_split want;
        if (i_rst_n && o_valid && !i_stall) begin
            received++;
            if (pending_splits.size() == 0) begin
                $error("result with nothing expected: status %0d", o_status);
                errors++;
            end else begin
                want = pending_splits.pop_front();
                if (o_status == ST_ORDER) order_splits++;
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
                if (o_factor_one !== want.factor_one) begin
                    $error("factor_one: expected %0d, got %0d", want.factor_one, o_factor_one);
                    errors++;
                end
                if (o_factor_two !== want.factor_two) begin
                    $error("factor_two: expected %0d, got %0d", want.factor_two, o_factor_two);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        rows = '{
            '{32'd0, 32'd5, 1'b1, '{ST_INVALID, 32'd1, 32'd1}},
            '{32'd1, 32'hFFFF_FFFF, 1'b1, '{ST_INVALID, 32'd1, 32'd1}},
            '{32'd3, 32'd2, 1'b1, '{ST_INVALID, 32'd1, 32'd1}},
            '{32'd4, 32'd3, 1'b1, '{ST_EVEN, 32'd2, 32'd2}},
            '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, '{ST_EVEN, 32'd2, 32'h7FFF_FFFF}},
            '{32'hFFFF_FFFF, 32'd3, 1'b1, '{ST_GCD, 32'd3, 32'h5555_5555}},
            '{32'd7, 32'd3, 1'b1, '{ST_FAIL, 32'd1, 32'd1}},
            '{32'd7, 32'd14, 1'b1, '{ST_FAIL, 32'd1, 32'd1}},
            '{32'd15, 32'd30, 1'b1, '{ST_GCD, 32'd15, 32'd1}},
            '{32'd15, 32'hFFFF_FFFF, 1'b1, '{ST_GCD, 32'd15, 32'd1}},
            '{32'd15, 32'd14, 1'b1, '{ST_FAIL, 32'd1, 32'd1}},
            '{32'd21, 32'd4, 1'b1, '{ST_FAIL, 32'd1, 32'd1}},
            '{32'd15, 32'd2, 1'b0, '0},
            '{32'd21, 32'd2, 1'b0, '0},
            '{32'd9, 32'd2, 1'b0, '0},
            '{32'd25, 32'd7, 1'b0, '0},
            '{32'd255, 32'd2, 1'b0, '0},
            '{32'd221, 32'hFFFF_FFF0, 1'b0, '0},
            '{32'd5, 32'd0, 1'b0, '0}
        };
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[k]) send_request(rows[k].modulus, rows[k].base, rows[k].typed,
                                       rows[k].split);
        for (int k = 0; k < 100; k++) begin
            if (k == 50) begin
                i_valid <= 1'b0;
                wait (pending_splits.size() == 0);
                @(negedge i_clk);
            end
            send_random();
        end
        i_valid <= 1'b0;
        wait (pending_splits.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d requests (directed extremes, then random), got %0d results,",
                 sent, received);
        $display("%0d of them split by the order search.", order_splits);
        if (errors == 0 && pending_splits.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("Verification failed");
        $finish;
    end
endmodule
